[rtl/tcp_option_stream_parser_unit_assert.svh]
// Assertion macros for the TCP option stream parser checker.
// Needs nothing else; included by the checker file.
`ifndef TCP_OPTION_STREAM_PARSER_UNIT_ASSERT_SVH
`define TCP_OPTION_STREAM_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define TOSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tosp checker: property failed");

// next-cycle implication
`define TOSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tosp checker: property failed");

`endif

[rtl/tosp_pkg.sv]
// Shared types and constants for the TCP option stream parser.
// No dependencies; used by the parser top level and its checker.
`default_nettype none

package tosp_pkg;

    localparam int unsigned OUT_BITS   = 94;
    localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [7:0] KIND_EOL  = 8'd0;
    localparam logic [7:0] KIND_NOP  = 8'd1;
    localparam logic [7:0] KIND_MSS  = 8'd2;
    localparam logic [7:0] KIND_WS   = 8'd3;
    localparam logic [7:0] KIND_SACK = 8'd4;
    localparam logic [7:0] KIND_TS   = 8'd8;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_TRUNC   = 2'd1;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

    typedef enum logic [4:0] {
        OPT_IDLE = 5'b00001,
        OPT_MSS  = 5'b00010,
        OPT_WS   = 5'b00100,
        OPT_SACK = 5'b01000,
        OPT_TS   = 5'b10000
    } opt_state_t;

    function automatic logic [3:0] option_length(opt_state_t opt);
        logic [3:0] len;
        case (opt)
            OPT_MSS:  len = 4'd4;
            OPT_WS:   len = 4'd3;
            OPT_SACK: len = 4'd2;
            OPT_TS:   len = 4'd10;
            default:  len = 4'd1;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[rtl/tcp_option_stream_parser_unit.sv]
// TCP option stream parser: decodes one options area, one byte per cycle while s_axis_tready is high.
// Depends on tosp_pkg.
//
// Usage:
//   Input stream: one options byte per request on s_axis_tdata[7:0], with
//   s_axis_tlast high on the final byte of the area.
//   Output stream: one summary request per area on m_axis_tdata.
//   The summary is registered and appears in the cycle after the last byte is taken.
//   Throughput: one byte per cycle while s_axis_tready is high, sustained across
//   areas; the next area may start in the cycle after the last byte of the previous one.
//   The summary sits in a single output register; s_axis_tready drops only
//   while that register is full and m_axis_tready is low, so a stalled
//   receiver holds the input side after at most one pending summary.
//   Reset clears the parse state and empties the output register; the
//   first byte after reset is taken as an option kind.
//   Bytes after end of list or an unknown kind are dropped up to tlast.
//   Any error zeroes all present flags and values in the summary.
`default_nettype none

module tcp_option_stream_parser_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [7:0] opt_byte
    input  wire logic [7:0]                         s_axis_tdata,
    input  wire logic                               s_axis_tlast,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [0] mss_present, [16:1] mss_value, [17] wscale_present,
    // [25:18] wscale_shift, [26] sackok_present, [27] tstamp_present,
    // [59:28] tstamp_value, [91:60] tstamp_echo, [93:92] parse_status,
    // [95:94] zero
    output logic [tosp_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);
    import tosp_pkg::*;

    opt_state_t        cur_option_reg, cur_option_next;
    logic [3:0]        byte_pos_reg, byte_pos_next;
    logic              list_ended_reg, list_ended_next;
    logic [1:0]        err_code_reg, err_code_next;
    logic              mss_seen_reg, mss_seen_next;
    logic [15:0]       mss_acc_reg, mss_acc_next;
    logic              ws_seen_reg, ws_seen_next;
    logic [7:0]        ws_acc_reg, ws_acc_next;
    logic              sack_seen_reg, sack_seen_next;
    logic              ts_seen_reg, ts_seen_next;
    logic [31:0]       ts_val_acc_reg, ts_val_acc_next;
    logic [31:0]       ts_ecr_acc_reg, ts_ecr_acc_next;

    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic       accept;
    logic [7:0] b;
    logic [3:0] pos_inc;
    logic [1:0] status;
    logic       ok, m, w, s, t;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        cur_option_next = cur_option_reg;
        byte_pos_next   = byte_pos_reg;
        list_ended_next = list_ended_reg;
        err_code_next   = err_code_reg;
        mss_seen_next   = mss_seen_reg;
        mss_acc_next    = mss_acc_reg;
        ws_seen_next    = ws_seen_reg;
        ws_acc_next     = ws_acc_reg;
        sack_seen_next  = sack_seen_reg;
        ts_seen_next    = ts_seen_reg;
        ts_val_acc_next = ts_val_acc_reg;
        ts_ecr_acc_next = ts_ecr_acc_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        pos_inc         = byte_pos_reg + 4'd1;
        status          = STATUS_OK;
        ok = 1'b0;
        m  = 1'b0;
        w  = 1'b0;
        s  = 1'b0;
        t  = 1'b0;

        if (accept && !list_ended_reg && err_code_reg == STATUS_OK)
        begin
            if (cur_option_reg == OPT_IDLE)
            begin
                case (b)
                    KIND_EOL:  list_ended_next = 1'b1;
                    KIND_NOP:  ;
                    KIND_MSS:
                    begin
                        cur_option_next = OPT_MSS;
                        byte_pos_next   = 4'd1;
                    end
                    KIND_WS:
                    begin
                        cur_option_next = OPT_WS;
                        byte_pos_next   = 4'd1;
                    end
                    KIND_SACK:
                    begin
                        cur_option_next = OPT_SACK;
                        byte_pos_next   = 4'd1;
                    end
                    KIND_TS:
                    begin
                        cur_option_next = OPT_TS;
                        byte_pos_next   = 4'd1;
                    end
                    default:   err_code_next = STATUS_UNKNOWN;
                endcase
            end
            else
            begin
                if (cur_option_reg == OPT_MSS && byte_pos_reg >= 4'd2)
                    mss_acc_next = {mss_acc_reg[7:0], b};
                else if (cur_option_reg == OPT_WS && byte_pos_reg == 4'd2)
                    ws_acc_next = b;
                else if (cur_option_reg == OPT_TS && byte_pos_reg >= 4'd2
                         && byte_pos_reg <= 4'd5)
                    ts_val_acc_next = {ts_val_acc_reg[23:0], b};
                else if (cur_option_reg == OPT_TS && byte_pos_reg >= 4'd6)
                    ts_ecr_acc_next = {ts_ecr_acc_reg[23:0], b};

                if (pos_inc >= option_length(cur_option_reg))
                begin
                    case (cur_option_reg)
                        OPT_MSS:  mss_seen_next  = 1'b1;
                        OPT_WS:   ws_seen_next   = 1'b1;
                        OPT_SACK: sack_seen_next = 1'b1;
                        OPT_TS:   ts_seen_next   = 1'b1;
                        default:  ;
                    endcase
                    cur_option_next = OPT_IDLE;
                    byte_pos_next   = 4'd0;
                end
                else
                begin
                    byte_pos_next = pos_inc;
                end
            end
        end

        if (accept && s_axis_tlast)
        begin
            status = err_code_next;
            if (err_code_next == STATUS_OK && !list_ended_next
                && cur_option_next != OPT_IDLE)
                status = STATUS_TRUNC;
            ok = (status == STATUS_OK);
            m  = ok && mss_seen_next;
            w  = ok && ws_seen_next;
            s  = ok && sack_seen_next;
            t  = ok && ts_seen_next;

            out_valid_next = 1'b1;
            out_data_next  = {2'b00,
                              status,
                              t ? ts_ecr_acc_next : 32'd0,
                              t ? ts_val_acc_next : 32'd0,
                              t,
                              s,
                              w ? ws_acc_next : 8'd0,
                              w,
                              m ? mss_acc_next : 16'd0,
                              m};

            cur_option_next = OPT_IDLE;
            byte_pos_next   = 4'd0;
            list_ended_next = 1'b0;
            err_code_next   = STATUS_OK;
            mss_seen_next   = 1'b0;
            mss_acc_next    = 16'd0;
            ws_seen_next    = 1'b0;
            ws_acc_next     = 8'd0;
            sack_seen_next  = 1'b0;
            ts_seen_next    = 1'b0;
            ts_val_acc_next = 32'd0;
            ts_ecr_acc_next = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_option_reg <= OPT_IDLE;
            byte_pos_reg   <= 4'd0;
            list_ended_reg <= 1'b0;
            err_code_reg   <= STATUS_OK;
            mss_seen_reg   <= 1'b0;
            mss_acc_reg    <= 16'd0;
            ws_seen_reg    <= 1'b0;
            ws_acc_reg     <= 8'd0;
            sack_seen_reg  <= 1'b0;
            ts_seen_reg    <= 1'b0;
            ts_val_acc_reg <= 32'd0;
            ts_ecr_acc_reg <= 32'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cur_option_reg <= cur_option_next;
            byte_pos_reg   <= byte_pos_next;
            list_ended_reg <= list_ended_next;
            err_code_reg   <= err_code_next;
            mss_seen_reg   <= mss_seen_next;
            mss_acc_reg    <= mss_acc_next;
            ws_seen_reg    <= ws_seen_next;
            ws_acc_reg     <= ws_acc_next;
            sack_seen_reg  <= sack_seen_next;
            ts_seen_reg    <= ts_seen_next;
            ts_val_acc_reg <= ts_val_acc_next;
            ts_ecr_acc_reg <= ts_ecr_acc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

[rtl/tosp_checker.sv]
// Port-level checker for the TCP option stream parser, bound to the top level.
// Depends on tosp_pkg and tcp_option_stream_parser_unit_assert.svh.
`default_nettype none

`include "tcp_option_stream_parser_unit_assert.svh"

module tosp_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic                              s_axis_tlast,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [tosp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import tosp_pkg::*;

    logic [1:0] status;
    logic [1:0] pad;
    logic       status_bad;
    logic       out_stall;
    logic       err_out;
    logic       ts_absent;
    logic       in_done;

    assign status     = m_axis_tdata[93:92];
    assign pad        = m_axis_tdata[95:94];
    assign status_bad = (status > STATUS_UNKNOWN) || (pad != 2'b00);
    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign err_out    = m_axis_tvalid && (status != STATUS_OK);
    assign ts_absent  = m_axis_tvalid && !m_axis_tdata[27];
    assign in_done    = s_axis_tvalid && s_axis_tready && s_axis_tlast;

    `TOSP_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
    `TOSP_ASSERT_IMP(a_status_code, clk, rst_n, m_axis_tvalid, !status_bad)
    `TOSP_ASSERT_IMP(a_err_clears, clk, rst_n, err_out, m_axis_tdata[91:0] == 92'd0)
    `TOSP_ASSERT_IMP(a_absent_zero, clk, rst_n, ts_absent, m_axis_tdata[91:28] == 64'd0)
    `TOSP_ASSERT_NXT(a_summary_follows, clk, rst_n, in_done, m_axis_tvalid)

endmodule

bind tcp_option_stream_parser_unit tosp_checker u_tosp_checker (.*);

`default_nettype wire

[tb/tb_tcp_option_stream_parser_unit.sv]
// Self-checking bench for tcp_option_stream_parser_unit: options areas go in byte by byte,
// and each summary is checked against an in-bench parser that keeps its own option state.
// Depends on tosp_pkg and the parser RTL.
module tb_tcp_option_stream_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tosp_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int BYTES_PER_PHASE = 325;

    typedef struct packed {
        logic        last;
        logic [7:0]  value;
    } opt_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] tstamp_echo;
        logic [31:0] tstamp_value;
        logic        tstamp_present;
        logic        sackok_present;
        logic [7:0]  wscale_shift;
        logic        wscale_present;
        logic [15:0] mss_value;
        logic        mss_present;
    } opt_summary_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [7:0]                   s_axis_tdata = '0;
    logic                         s_axis_tlast = 1'b0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]       m_axis_tdata;

    opt_req_t      byte_queue[$];
    logic [7:0]    area_bytes[$];
    opt_summary_t  summaries_due[$];
    opt_req_t      next_req;
    opt_summary_t  got_summary;
    opt_summary_t  want_summary;

    int error_count = 0;
    int bytes_queued = 0;
    int bytes_taken = 0;
    int areas_queued = 0;
    int summaries_checked = 0;
    int trunc_seen = 0;
    int unknown_seen = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int send_idle_by_phase[4] = '{0, 75, 0, 35};
    int recv_stall_by_phase[4] = '{0, 0, 75, 35};

    opt_state_t  cur_opt = OPT_IDLE;
    logic [3:0]  opt_pos = '0;
    logic [3:0]  opt_len = '0;
    logic        eol_seen = 1'b0;
    logic [1:0]  parse_err = STATUS_OK;
    logic        mss_seen = 1'b0;
    logic [15:0] mss_acc = '0;
    logic        ws_seen = 1'b0;
    logic [7:0]  ws_acc = '0;
    logic        sack_seen = 1'b0;
    logic        ts_seen = 1'b0;
    logic [31:0] ts_val_acc = '0;
    logic [31:0] ts_ecr_acc = '0;

    tcp_option_stream_parser_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic int kind_length(input logic [7:0] kind);
        case (kind)
            KIND_MSS:  return 4;
            KIND_WS:   return 3;
            KIND_SACK: return 2;
            KIND_TS:   return 10;
            default:   return 1;
        endcase
    endfunction

    function automatic bit is_known_kind(input logic [7:0] kind);
        return kind == KIND_EOL || kind == KIND_NOP || kind == KIND_MSS ||
               kind == KIND_WS || kind == KIND_SACK || kind == KIND_TS;
    endfunction

    task automatic flag_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic parse_option_byte(input logic [7:0] b, input logic last);
        opt_summary_t sum;
        logic         ok;
        if (!eol_seen && parse_err == STATUS_OK)
        begin
            if (cur_opt == OPT_IDLE)
            begin
                case (b)
                    KIND_EOL: eol_seen = 1'b1;
                    KIND_NOP: ;
                    KIND_MSS: cur_opt = OPT_MSS;
                    KIND_WS:  cur_opt = OPT_WS;
                    KIND_SACK: cur_opt = OPT_SACK;
                    KIND_TS:  cur_opt = OPT_TS;
                    default:  parse_err = STATUS_UNKNOWN;
                endcase
                if (cur_opt != OPT_IDLE)
                begin
                    opt_pos = 4'd1;
                    opt_len = 4'(kind_length(b));
                end
            end
            else
            begin
                case (cur_opt)
                    OPT_MSS: if (opt_pos >= 2) mss_acc = {mss_acc[7:0], b};
                    OPT_WS:  if (opt_pos == 2) ws_acc = b;
                    OPT_TS:
                        if (opt_pos >= 2 && opt_pos <= 5) ts_val_acc = {ts_val_acc[23:0], b};
                        else if (opt_pos >= 6) ts_ecr_acc = {ts_ecr_acc[23:0], b};
                    default: ;
                endcase
                opt_pos = opt_pos + 4'd1;
                if (opt_pos >= opt_len)
                begin
                    case (cur_opt)
                        OPT_MSS:  mss_seen = 1'b1;
                        OPT_WS:   ws_seen = 1'b1;
                        OPT_SACK: sack_seen = 1'b1;
                        OPT_TS:   ts_seen = 1'b1;
                        default:  ;
                    endcase
                    cur_opt = OPT_IDLE;
                    opt_pos = '0;
                end
            end
        end
        if (last)
        begin
            if (parse_err == STATUS_OK && !eol_seen && cur_opt != OPT_IDLE)
                parse_err = STATUS_TRUNC;
            ok = (parse_err == STATUS_OK);
            sum = '0;
            sum.status = parse_err;
            if (ok)
            begin
                sum.mss_present    = mss_seen;
                sum.mss_value      = mss_seen ? mss_acc : 16'd0;
                sum.wscale_present = ws_seen;
                sum.wscale_shift   = ws_seen ? ws_acc : 8'd0;
                sum.sackok_present = sack_seen;
                sum.tstamp_present = ts_seen;
                sum.tstamp_value   = ts_seen ? ts_val_acc : 32'd0;
                sum.tstamp_echo    = ts_seen ? ts_ecr_acc : 32'd0;
            end
            summaries_due.push_back(sum);
            cur_opt = OPT_IDLE;
            opt_pos = '0;
            opt_len = '0;
            eol_seen = 1'b0;
            parse_err = STATUS_OK;
            mss_seen = 1'b0;
            mss_acc = '0;
            ws_seen = 1'b0;
            ws_acc = '0;
            sack_seen = 1'b0;
            ts_seen = 1'b0;
            ts_val_acc = '0;
            ts_ecr_acc = '0;
        end
    endtask

    task automatic queue_area();
        opt_req_t req;
        for (int i = 0; i < area_bytes.size(); i++)
        begin
            req.value = area_bytes[i];
            req.last = (i == area_bytes.size() - 1);
            byte_queue.push_back(req);
        end
        bytes_queued += area_bytes.size();
        areas_queued++;
        area_bytes.delete();
    endtask

    task automatic append_option(input logic [7:0] kind);
        int len;
        len = kind_length(kind);
        area_bytes.push_back(kind);
        if (len > 1)
            area_bytes.push_back($urandom_range(1) ? 8'(len) : 8'($urandom_range(255)));
        for (int i = 2; i < len; i++)
            area_bytes.push_back(8'($urandom_range(255)));
    endtask

    function automatic logic [7:0] random_kind(input bit with_nop);
        int pick;
        pick = $urandom_range(with_nop ? 0 : 2, 9);
        if (pick < 2) return KIND_NOP;
        if (pick < 4) return KIND_MSS;
        if (pick < 6) return KIND_WS;
        if (pick < 7) return KIND_SACK;
        return KIND_TS;
    endfunction

    task automatic queue_random_area();
        int          mode;
        int          n_opts;
        int          cut;
        logic [7:0]  kind;
        mode = $urandom_range(99);
        n_opts = (mode < 70) ? $urandom_range(0, 6) : $urandom_range(0, 3);
        if (mode >= 95)
        begin
            repeat ($urandom_range(1, 12)) area_bytes.push_back(8'($urandom_range(255)));
        end
        else
        begin
            repeat (n_opts) append_option(random_kind(1'b1));
            if (mode < 70)
            begin
                if ($urandom_range(3) == 0)
                begin
                    area_bytes.push_back(KIND_EOL);
                    repeat ($urandom_range(0, 4))
                        area_bytes.push_back(8'($urandom_range(255)));
                end
            end
            else if (mode < 85)
            begin
                kind = random_kind(1'b0);
                append_option(kind);
                cut = $urandom_range(1, kind_length(kind) - 1);
                repeat (cut) void'(area_bytes.pop_back());
            end
            else
            begin
                do kind = 8'($urandom_range(255)); while (is_known_kind(kind));
                area_bytes.push_back(kind);
                repeat ($urandom_range(0, 4)) area_bytes.push_back(8'($urandom_range(255)));
            end
        end
        if (area_bytes.size() == 0)
            area_bytes.push_back(KIND_NOP);
        queue_area();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tlast <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                parse_option_byte(s_axis_tdata, s_axis_tlast);
                bytes_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_req = byte_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= next_req.value;
                    s_axis_tlast <= next_req.last;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_summary = m_axis_tdata[OUT_BITS-1:0];
                if (m_axis_tdata[OUT_TDATA_W-1:OUT_BITS] !== '0)
                    flag_mismatch("tdata pad bits not zero");
                if (summaries_due.size() == 0)
                begin
                    flag_mismatch("summary with no area pending");
                end
                else
                begin
                    want_summary = summaries_due.pop_front();
                    summaries_checked++;
                    if (want_summary.status == STATUS_TRUNC) trunc_seen++;
                    if (want_summary.status == STATUS_UNKNOWN) unknown_seen++;
                    if (got_summary.mss_present !== want_summary.mss_present)
                        flag_mismatch($sformatf("mss_present got %0d want %0d",
                            got_summary.mss_present, want_summary.mss_present));
                    if (got_summary.mss_value !== want_summary.mss_value)
                        flag_mismatch($sformatf("mss_value got %h want %h",
                            got_summary.mss_value, want_summary.mss_value));
                    if (got_summary.wscale_present !== want_summary.wscale_present)
                        flag_mismatch($sformatf("wscale_present got %0d want %0d",
                            got_summary.wscale_present, want_summary.wscale_present));
                    if (got_summary.wscale_shift !== want_summary.wscale_shift)
                        flag_mismatch($sformatf("wscale_shift got %h want %h",
                            got_summary.wscale_shift, want_summary.wscale_shift));
                    if (got_summary.sackok_present !== want_summary.sackok_present)
                        flag_mismatch($sformatf("sackok_present got %0d want %0d",
                            got_summary.sackok_present, want_summary.sackok_present));
                    if (got_summary.tstamp_present !== want_summary.tstamp_present)
                        flag_mismatch($sformatf("tstamp_present got %0d want %0d",
                            got_summary.tstamp_present, want_summary.tstamp_present));
                    if (got_summary.tstamp_value !== want_summary.tstamp_value)
                        flag_mismatch($sformatf("tstamp_value got %h want %h",
                            got_summary.tstamp_value, want_summary.tstamp_value));
                    if (got_summary.tstamp_echo !== want_summary.tstamp_echo)
                        flag_mismatch($sformatf("tstamp_echo got %h want %h",
                            got_summary.tstamp_echo, want_summary.tstamp_echo));
                    if (got_summary.status !== want_summary.status)
                        flag_mismatch($sformatf("parse_status got %0d want %0d",
                            got_summary.status, want_summary.status));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
                $display("tcp_option_stream_parser_unit regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        @(posedge rst_n);
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = send_idle_by_phase[phase];
            recv_stall_pct = recv_stall_by_phase[phase];
            if (phase == 0)
            begin
                area_bytes = '{KIND_MSS, 8'h04, 8'h00, 8'h00, KIND_WS, 8'h03, 8'hFF};
                queue_area();
                area_bytes = '{KIND_TS, 8'h0A, 8'h12, 8'h34, 8'h56, 8'h78,
                               8'h9A, 8'hBC, 8'hDE, 8'hF0};
                queue_area();
                area_bytes = '{KIND_NOP, KIND_SACK, 8'h02, KIND_EOL};
                queue_area();
                area_bytes = '{8'h05};
                queue_area();
                area_bytes = '{KIND_MSS, 8'h04, 8'hFF};
                queue_area();
                area_bytes = '{8'hFF};
                queue_area();
                area_bytes = '{KIND_EOL};
                queue_area();
            end
            while (bytes_queued < (phase + 1) * BYTES_PER_PHASE)
                queue_random_area();
            // hold new areas until every summary of this phase is back
            while (byte_queue.size() != 0 || bytes_taken != bytes_queued ||
                   summaries_due.size() != 0)
                @(posedge clk);
        end
        recv_stall_pct = 0;
        repeat (8) @(posedge clk);
        $display("covered %0d option bytes in %0d areas across 4 handshake phases",
                 bytes_taken, areas_queued);
        $display("checked %0d summaries: %0d truncated, %0d unknown kind",
                 summaries_checked, trunc_seen, unknown_seen);
        if (error_count == 0)
            $display("tcp_option_stream_parser_unit regression: pass");
        else
            $display("tcp_option_stream_parser_unit regression: fail");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/tosp_pkg.sv
rtl/tcp_option_stream_parser_unit.sv
rtl/tosp_checker.sv
tb/tb_tcp_option_stream_parser_unit.sv
